### rtl/chf_pkg.sv
// shared types, constants and the arctangent table for the compass heading block
package chf_pkg;

    // default and largest number of micro-rotation cells
    localparam int ANGLE_STEPS_DEF = 16;
    localparam int ATAN_TABLE_LEN  = 24;

    // field component width and internal vector width (18 integer bits, sign, 16 fraction)
    localparam int MAG_W  = 16;
    localparam int FRAC_W = 16;
    localparam int VEC_W  = 35;

    // binary angle: a full turn is 2^ANG_W
    localparam int ANG_W = 32;
    localparam logic [ANG_W-1:0] ANG_ZERO = '0;
    localparam logic [ANG_W-1:0] ANG_HALF = {1'b1, {(ANG_W-1){1'b0}}};

    // heading scaling
    localparam int                 TENTHS_W        = 12;
    localparam logic [TENTHS_W-1:0] TENTHS_PER_TURN = 12'd3600;
    localparam int                 PROD_W          = ANG_W + TENTHS_W;
    localparam logic [PROD_W-1:0]  ROUND_HALF      = {{(TENTHS_W+1){1'b0}}, {(ANG_W-1){1'b0}}} |
                                                     (PROD_W'(1) << (ANG_W-1));

    // word passed along the rotation chain
    typedef struct packed {
        logic             zero;
        logic [ANG_W-1:0] ang;
        logic [VEC_W-1:0] x;
        logic [VEC_W-1:0] y;
    } t_cell_data;

    // word between the multiply and rounding stages
    typedef struct packed {
        logic              zero;
        logic [PROD_W-1:0] prod;
    } t_prod_data;

    // atan(2^-idx) as a binary angle, rounded to nearest
    function automatic logic [ANG_W-1:0] atan_entry(input int idx);
        logic [ANG_W-1:0] v;
        unique case (idx)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2FA;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            23:      v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

### rtl/chf_pre.sv
// input stage: fold into the right half plane, scale up and flag the zero vector
module chf_pre (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [chf_pkg::MAG_W-1:0] i_mag_x,
    input  logic [chf_pkg::MAG_W-1:0] i_mag_y,
    output logic                      o_valid,
    input  logic                      i_ready,
    output chf_pkg::t_cell_data       o_data
);

    localparam int EXT_W = chf_pkg::MAG_W + 1;

    logic                      r_valid;
    chf_pkg::t_cell_data       r_data;
    chf_pkg::t_cell_data       n_data;
    logic signed [EXT_W-1:0]   x_ext;
    logic signed [EXT_W-1:0]   y_ext;
    logic signed [EXT_W-1:0]   x_fold;
    logic signed [EXT_W-1:0]   y_fold;
    logic                      x_neg;

    // sign extend by one bit so that negating -32768 stays exact
    assign x_ext = {i_mag_x[chf_pkg::MAG_W-1], i_mag_x};
    assign y_ext = {i_mag_y[chf_pkg::MAG_W-1], i_mag_y};
    assign x_neg = i_mag_x[chf_pkg::MAG_W-1];

    // rotate by half a turn when x is negative
    always_comb begin
        x_fold      = x_neg ? -x_ext : x_ext;
        y_fold      = x_neg ? -y_ext : y_ext;
        n_data.zero = (i_mag_x == '0) && (i_mag_y == '0);
        n_data.ang  = x_neg ? chf_pkg::ANG_HALF : chf_pkg::ANG_ZERO;
        n_data.x    = {{(chf_pkg::VEC_W-EXT_W-chf_pkg::FRAC_W){x_fold[EXT_W-1]}},
                       x_fold, {chf_pkg::FRAC_W{1'b0}}};
        n_data.y    = {{(chf_pkg::VEC_W-EXT_W-chf_pkg::FRAC_W){y_fold[EXT_W-1]}},
                       y_fold, {chf_pkg::FRAC_W{1'b0}}};
    end

    // stage register
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### rtl/chf_cell.sv
// one cordic vectoring micro-rotation with its own stage register
module chf_cell #(
    parameter int STEP = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  chf_pkg::t_cell_data i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output chf_pkg::t_cell_data o_data
);

    localparam logic [chf_pkg::ANG_W-1:0] ATAN = chf_pkg::atan_entry(STEP);

    logic                              r_valid;
    chf_pkg::t_cell_data               r_data;
    chf_pkg::t_cell_data               n_data;
    logic signed [chf_pkg::VEC_W-1:0]  x_cur;
    logic signed [chf_pkg::VEC_W-1:0]  y_cur;
    logic signed [chf_pkg::VEC_W-1:0]  x_sh;
    logic signed [chf_pkg::VEC_W-1:0]  y_sh;
    logic                              y_nonneg;

    // floor shifts of both parts
    assign x_cur    = $signed(i_data.x);
    assign y_cur    = $signed(i_data.y);
    assign x_sh     = x_cur >>> STEP;
    assign y_sh     = y_cur >>> STEP;
    assign y_nonneg = !i_data.y[chf_pkg::VEC_W-1];

    // clockwise when y is zero or positive, else counterclockwise
    always_comb begin
        n_data.zero = i_data.zero;
        if (y_nonneg) begin
            n_data.x   = chf_pkg::VEC_W'(x_cur + y_sh);
            n_data.y   = chf_pkg::VEC_W'(y_cur - x_sh);
            n_data.ang = i_data.ang + ATAN;
        end else begin
            n_data.x   = chf_pkg::VEC_W'(x_cur - y_sh);
            n_data.y   = chf_pkg::VEC_W'(y_cur + x_sh);
            n_data.ang = i_data.ang - ATAN;
        end
    end

    // stage register
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### rtl/chf_scale.sv
// output stages: binary angle times 3600, then round, wrap and zero override
module chf_scale (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  chf_pkg::t_cell_data          i_data,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [chf_pkg::TENTHS_W-1:0] o_heading_tenths
);

    logic                          r_prod_valid;
    chf_pkg::t_prod_data           r_prod;
    chf_pkg::t_prod_data           n_prod;
    logic                          prod_ready;
    logic                          r_out_valid;
    logic [chf_pkg::TENTHS_W-1:0]  r_tenths;
    logic [chf_pkg::TENTHS_W-1:0]  n_tenths;
    logic [chf_pkg::PROD_W-1:0]    rounded;

    // multiply stage
    always_comb begin
        n_prod.zero = i_data.zero;
        n_prod.prod = chf_pkg::PROD_W'(i_data.ang) *
                      chf_pkg::PROD_W'(chf_pkg::TENTHS_PER_TURN);
    end

    assign o_ready = !r_prod_valid || prod_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else if (o_ready) begin
            r_prod_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prod <= n_prod;
        end
    end

    // round to nearest tenth, a full turn wraps to zero
    assign rounded = r_prod.prod + chf_pkg::ROUND_HALF;

    always_comb begin
        n_tenths = rounded[chf_pkg::PROD_W-1:chf_pkg::ANG_W];
        if (r_prod.zero || (n_tenths >= chf_pkg::TENTHS_PER_TURN)) begin
            n_tenths = '0;
        end
    end

    assign prod_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (prod_ready) begin
            r_out_valid <= r_prod_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (prod_ready && r_prod_valid) begin
            r_tenths <= n_tenths;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_heading_tenths = r_tenths;

endmodule

### rtl/compass_heading_from_field.sv
// Compass heading from a signed field pair (x, y): atan2(y, x) in tenths of a degree, 0 to 3599.
// The angle comes from a pipelined CORDIC: an input stage folds the vector into the right half
// plane, then a chain of ANGLE_STEPS cells (at most 24, one micro-rotation each), a multiply
// stage and a round stage. A new word is taken every cycle while results are taken at the
// output. Every stage has its own valid bit and registers, so input is still accepted while
// a finished result waits, as long as some stage ahead is empty.
// The zero vector gives a heading of 0.
module compass_heading_from_field #(
    parameter int ANGLE_STEPS = chf_pkg::ANGLE_STEPS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [chf_pkg::MAG_W-1:0]    i_mag_x,
    input  logic [chf_pkg::MAG_W-1:0]    i_mag_y,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [chf_pkg::TENTHS_W-1:0] o_heading_tenths
);

    localparam int CELLS = (ANGLE_STEPS > chf_pkg::ATAN_TABLE_LEN) ?
                           chf_pkg::ATAN_TABLE_LEN : ANGLE_STEPS;

    chf_pkg::t_cell_data chain_data  [CELLS+1];
    logic                chain_valid [CELLS+1];
    logic                chain_ready [CELLS+1];

    // input fold and scale
    chf_pre u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_mag_x (i_mag_x),
        .i_mag_y (i_mag_y),
        .o_valid (chain_valid[0]),
        .i_ready (chain_ready[0]),
        .o_data  (chain_data[0])
    );

    // micro-rotation chain
    for (genvar k = 0; k < CELLS; k++) begin : g_cell
        chf_cell #(
            .STEP (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[k]),
            .o_ready (chain_ready[k]),
            .i_data  (chain_data[k]),
            .o_valid (chain_valid[k+1]),
            .i_ready (chain_ready[k+1]),
            .o_data  (chain_data[k+1])
        );
    end

    // conversion to tenths of a degree
    chf_scale u_scale (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (chain_valid[CELLS]),
        .o_ready          (chain_ready[CELLS]),
        .i_data           (chain_data[CELLS]),
        .o_valid          (o_out_valid),
        .i_ready          (i_out_ready),
        .o_heading_tenths (o_heading_tenths)
    );

endmodule

### tb/tb_compass_heading_from_field.sv
// self-checking testbench for the compass heading block: directed and random field pairs
`timescale 1ns / 1ps

// predicts headings for accepted field words and checks the returned words in order
class heading_scoreboard;

    // atan(2^-i) as a binary angle, entry i at bits [32*i +: 32]
    localparam logic [32*24-1:0] ARC_TAB = {
        32'h00000051, 32'h000000A3, 32'h00000146, 32'h0000028C,
        32'h00000518, 32'h00000A30, 32'h0000145F, 32'h000028BE,
        32'h0000517D, 32'h0000A2FA, 32'h000145F3, 32'h00028BE6,
        32'h000517CC, 32'h000A2F98, 32'h00145F2F, 32'h0028BE53,
        32'h00517C55, 32'h00A2F61E, 32'h0145D7E1, 32'h028B0D43,
        32'h051111D4, 32'h09FB385B, 32'h12E4051E, 32'h20000000
    };

    int                           rot_steps;
    int                           n_taken;
    int                           n_errors;
    logic [chf_pkg::TENTHS_W-1:0] heading_q[$];

    function new(int n_steps);
        rot_steps = (n_steps > 24) ? 24 : n_steps;
        n_taken   = 0;
        n_errors  = 0;
    endfunction

    // cordic vectoring on a 64-bit vector, angle as a 32-bit binary angle
    function logic [chf_pkg::TENTHS_W-1:0] heading_of(logic [15:0] fx, logic [15:0] fy);
        longint                  vx;
        longint                  vy;
        longint                  sx;
        longint                  sy;
        logic [chf_pkg::ANG_W-1:0] ang;
        logic [63:0]             prod;
        vx  = signed'(fx);
        vy  = signed'(fy);
        ang = chf_pkg::ANG_ZERO;
        if (vx == 0 && vy == 0) begin
            return '0;
        end
        // fold into the right half plane
        if (vx < 0) begin
            vx  = -vx;
            vy  = -vy;
            ang = chf_pkg::ANG_HALF;
        end
        vx = vx * 65536;
        vy = vy * 65536;
        for (int i = 0; i < rot_steps; i++) begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (vy >= 0) begin
                vx  = vx + sy;
                vy  = vy - sx;
                ang = ang + ARC_TAB[32*i +: 32];
            end else begin
                vx  = vx - sy;
                vy  = vy + sx;
                ang = ang - ARC_TAB[32*i +: 32];
            end
        end
        // scale to tenths with rounding, a full turn wraps to zero
        prod = 64'(ang) * 64'd3600 + 64'h0000_0000_8000_0000;
        if (prod[63:32] >= 32'(chf_pkg::TENTHS_PER_TURN)) begin
            return '0;
        end
        return prod[32 +: chf_pkg::TENTHS_W];
    endfunction

    function void note_field(logic [15:0] fx, logic [15:0] fy);
        heading_q.push_back(heading_of(fx, fy));
        n_taken++;
    endfunction

    function void check_heading(logic [chf_pkg::TENTHS_W-1:0] got);
        logic [chf_pkg::TENTHS_W-1:0] exp_h;
        if (heading_q.size() == 0) begin
            $display("%0t: heading word %0d with nothing pending", $time, got);
            n_errors++;
            return;
        end
        exp_h = heading_q.pop_front();
        if (got !== exp_h) begin
            $display("%0t: heading_tenths expected %0d, actual %0d", $time, exp_h, got);
            n_errors++;
        end
    endfunction

endclass

module tb_compass_heading_from_field;

    localparam int STEPS      = 16;
    localparam int N_RANDOM   = 1900;
    localparam int N_CALM     = 300;
    localparam int HOLD_AT    = 700;
    localparam int HOLD_CYC   = 400;
    localparam int CYCLE_CAP  = 400000;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_ready;
    logic [chf_pkg::MAG_W-1:0]    i_mag_x;
    logic [chf_pkg::MAG_W-1:0]    i_mag_y;
    logic                         o_out_valid;
    logic                         i_out_ready;
    logic [chf_pkg::TENTHS_W-1:0] o_heading_tenths;

    heading_scoreboard sb = new(STEPS);
    bit                calm;
    int                cycles;

    compass_heading_from_field #(
        .ANGLE_STEPS(STEPS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_mag_x          (i_mag_x),
        .i_mag_y          (i_mag_y),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_heading_tenths (o_heading_tenths)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // cycle cap
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_CAP) begin
                $display("tb_compass_heading_from_field: done, errors");
                $finish;
            end
        end
    end

    // offer one field word and hold it until taken
    task automatic send_pair(input int x, input int y);
        i_in_valid <= 1'b1;
        i_mag_x    <= 16'(x);
        i_mag_y    <= 16'(y);
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_field(16'(x), 16'(y));
    endtask

    task automatic sender_gap(input int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // pick a component from the edges of the range
    function automatic int edge_val();
        int pick;
        pick = $urandom_range(0, 5);
        case (pick)
            0:       return -32768;
            1:       return -32767;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            default: return 32767;
        endcase
    endfunction

    // result side: check taken words, drive ready with bursts and one long hold
    initial begin
        int hold_left;
        int gap_left;
        int span_cyc;
        bit span_idle;
        bit long_done;
        hold_left = 0;
        gap_left  = 0;
        span_cyc  = 0;
        span_idle = 1'b1;
        long_done = 1'b0;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (i_out_ready && o_out_valid) begin
                sb.check_heading(o_heading_tenths);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!long_done && sb.n_taken >= HOLD_AT) begin
                // long hold so the pipe fills and backs up the input
                long_done = 1'b1;
                hold_left = HOLD_CYC - 1;
                i_out_ready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                i_out_ready <= 1'b0;
            end else if (!calm && span_idle && $urandom_range(0, 4) == 0) begin
                gap_left = $urandom_range(1, 18) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
            span_cyc++;
            if (span_cyc == 250) begin
                span_cyc  = 0;
                span_idle = ($urandom_range(0, 2) != 0);
            end
        end
    end

    // stimulus
    initial begin
        int  sel;
        int  x;
        int  y;
        int  m;
        bit  span_idle;
        calm = 1'b0;
        span_idle = 1'b1;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_mag_x    <= '0;
        i_mag_y    <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: axes, extremes, zero vector, both fold cases, wrap of a full turn
        send_pair(0, 0);
        send_pair(32767, 0);
        send_pair(-32768, 0);
        send_pair(0, 32767);
        send_pair(0, -32768);
        send_pair(1, 0);
        send_pair(-1, 0);
        send_pair(0, 1);
        send_pair(0, -1);
        send_pair(32767, 32767);
        send_pair(-32768, -32768);
        send_pair(-32768, 32767);
        send_pair(32767, -32768);
        send_pair(-1, -1);
        send_pair(1, -1);
        send_pair(-1, 1);
        send_pair(32767, -1);
        send_pair(32767, 1);
        send_pair(-32768, -1);
        send_pair(-32768, 1);
        send_pair(-32767, -32768);
        send_pair(0, 0);
        send_pair(12345, -23456);
        send_pair(-20000, 5);

        // random part
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - N_CALM) begin
                calm = 1'b1;
            end
            if (n % 150 == 0) begin
                span_idle = ($urandom_range(0, 2) != 0);
            end
            sel = $urandom_range(0, 9);
            case (sel)
                5: begin
                    x = int'($urandom_range(0, 8)) - 4;
                    y = int'($urandom_range(0, 8)) - 4;
                end
                6: begin
                    // on or next to an axis
                    m = int'($urandom_range(0, 65535)) - 32768;
                    if ($urandom_range(0, 1) == 1) begin
                        x = m;
                        y = int'($urandom_range(0, 4)) - 2;
                    end else begin
                        x = int'($urandom_range(0, 4)) - 2;
                        y = m;
                    end
                end
                7: begin
                    x = edge_val();
                    y = edge_val();
                end
                8: begin
                    // diagonals
                    m = int'($urandom_range(0, 32767));
                    x = ($urandom_range(0, 1) == 1) ? -m : m;
                    y = ($urandom_range(0, 1) == 1) ? -m : m;
                end
                9: begin
                    if ($urandom_range(0, 3) == 0) begin
                        x = 0;
                        y = 0;
                    end else begin
                        x = int'($urandom_range(0, 65535)) - 32768;
                        y = int'($urandom_range(0, 65535)) - 32768;
                    end
                end
                default: begin
                    x = int'($urandom_range(0, 65535)) - 32768;
                    y = int'($urandom_range(0, 65535)) - 32768;
                end
            endcase
            send_pair(x, y);
            if (!calm && span_idle && $urandom_range(0, 3) == 0) begin
                sender_gap($urandom_range(1, 18));
            end
        end
        i_in_valid <= 1'b0;

        // drain
        while (sb.heading_q.size() != 0) @(posedge i_clk);
        repeat (STEPS + 8) @(posedge i_clk);
        if (sb.n_errors == 0) begin
            $display("tb_compass_heading_from_field: done, clean");
        end else begin
            $display("tb_compass_heading_from_field: done, errors");
        end
        $finish;
    end

endmodule
